@@ hdl/ctt_pkg.sv @@
`timescale 1ns / 1ps

package ctt_pkg;

  localparam int NUM_CHANNELS = 3;
  localparam int COUNT_BITS   = 16;
  localparam int MARGIN_BITS  = 16;
  localparam int TRAIN_BITS   = 8;
  localparam int CFG_BITS     = 16;
  localparam int INDEX_BITS   = 2;

  localparam int IN_FIELD_BITS  = NUM_CHANNELS * COUNT_BITS;
  localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int RES_BITS       = 2 * NUM_CHANNELS + 1;
  localparam int OUT_TDATA_BITS = ((RES_BITS + 7) / 8) * 8;

  localparam logic [COUNT_BITS-1:0]  TRIP_DELTA_RESET     = COUNT_BITS'(6);
  localparam logic [MARGIN_BITS-1:0] RELEASE_MARGIN_RESET = MARGIN_BITS'(4);
  localparam logic [TRAIN_BITS-1:0]  TRAINING_RESET       = TRAIN_BITS'(64);

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [NUM_CHANNELS-1:0] chan_mask_t;

  typedef enum logic [INDEX_BITS-1:0] {
    REG_TRIP_DELTA     = 2'd0,
    REG_RELEASE_MARGIN = 2'd1,
    REG_TRAINING       = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0]  trip_delta;
    logic [MARGIN_BITS-1:0] release_margin;
  } ctt_cfg_t;

  // Packed so that toggle_bits lands in the lowest bits.
  typedef struct packed {
    chan_mask_t tripped_mask;
    logic       touch_event;
    chan_mask_t toggle_bits;
  } result_t;

endpackage

@@ hdl/ctt_chan.sv @@
`timescale 1ns / 1ps

module ctt_chan
  import ctt_pkg::*;
(
  input  logic     armed,
  input  count_t   cnt,
  input  count_t   last,
  input  count_t   level,
  input  ctt_cfg_t cfg,
  output logic     trip,
  output count_t   level_next
);

  logic [COUNT_BITS:0]  drop;
  logic [COUNT_BITS:0]  raised;
  logic                 tripped;
  logic                 release_hit;

  always_comb begin
    drop        = {1'b0, last} - {1'b0, cnt};
    raised      = {1'b0, cnt} + (COUNT_BITS + 1)'(cfg.release_margin);
    tripped     = (level != '0);
    trip        = armed && !tripped && (last > cnt)
                  && ((COUNT_BITS + 1)'(drop) > (COUNT_BITS + 1)'(cfg.trip_delta));
    release_hit = armed && tripped && (raised > {1'b0, level});
    if (trip) begin
      level_next = last;
    end else if (release_hit) begin
      level_next = '0;
    end else begin
      level_next = level;
    end
  end

endmodule

@@ hdl/ctt_core.sv @@
`timescale 1ns / 1ps

module ctt_core
  import ctt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  count_t                counts [NUM_CHANNELS],
  input  ctt_cfg_t              cfg,
  input  logic                  train_load,
  input  logic [TRAIN_BITS-1:0] train_value,
  output result_t               res
);

  count_t                previous_count [NUM_CHANNELS];
  count_t                trip_level     [NUM_CHANNELS];
  count_t                level_next     [NUM_CHANNELS];
  chan_mask_t            toggle_state;
  chan_mask_t            trip_vec;
  chan_mask_t            tripped_next;
  logic [TRAIN_BITS-1:0] training_left;
  logic                  armed;

  assign armed = (training_left == '0);

  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
    localparam int B = NUM_CHANNELS - 1 - i;

    ctt_chan u_chan (
      .armed      (armed),
      .cnt        (counts[i]),
      .last       (previous_count[i]),
      .level      (trip_level[i]),
      .cfg        (cfg),
      .trip       (trip_vec[B]),
      .level_next (level_next[i])
    );

    assign tripped_next[B] = (level_next[i] != '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        previous_count[i] <= '0;
        trip_level[i]     <= '0;
      end else if (step) begin
        previous_count[i] <= counts[i];
        trip_level[i]     <= level_next[i];
      end
    end
  end

  always_comb begin
    res.toggle_bits  = toggle_state ^ trip_vec;
    res.touch_event  = |trip_vec;
    res.tripped_mask = tripped_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      toggle_state  <= '0;
      training_left <= TRAINING_RESET;
    end else begin
      if (step) begin
        toggle_state <= res.toggle_bits;
      end
      if (train_load) begin
        training_left <= train_value;
      end else if (step && !armed) begin
        training_left <= training_left - TRAIN_BITS'(1);
      end
    end
  end

endmodule

@@ hdl/cap_touch_toggle_detector.sv @@
`timescale 1ns / 1ps

// Capacitive touch detector with toggle outputs for three sense channels.
// Each input transfer on the s_ stream is one decode period carrying one
// sense count per channel. Each decode yields exactly one output transfer on
// the m_ stream with the toggle state, a touch event flag and the mask of
// channels currently latched as tripped.
// The input transfer is captured in an input register; the per-channel
// trip and release compares then run on it and the result is written to
// the output register when the pipeline advances. One decode per cycle is
// sustained while the receiver keeps m_tready high; the rate is set by the
// two-register pipeline, which advances whenever the output register is
// empty or being taken.
// When the receiver stalls, the result holds in the output register, the
// input register fills and then s_tready drops until m_tready returns.
// Configuration writes via cfg_we/cfg_index/cfg_data take effect at once
// and are meant to be made while no decode is in flight; writing the
// training count restarts training. Synchronous reset restores the default
// registers, clears all channel state and starts a 64-decode training run.
module cap_touch_toggle_detector
  import ctt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // count_first, count_second, count_third
  input  logic [IN_TDATA_BITS-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // toggle_bits, touch_event, tripped_mask, zero pad
  output logic [OUT_TDATA_BITS-1:0] m_tdata,
  input  logic                      cfg_we,
  input  logic [INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data
);

  ctt_cfg_t cfg;
  logic     in_valid;
  count_t   in_counts [NUM_CHANNELS];
  logic     advance;
  logic     step;
  logic     train_load;
  result_t  res;
  result_t  out_res;

  assign advance  = !m_tvalid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_in
    always_ff @(posedge clk) begin
      if (s_tvalid && s_tready) begin
        in_counts[i] <= s_tdata[i*COUNT_BITS +: COUNT_BITS];
      end
    end
  end

  assign train_load = cfg_we && (cfg_index == REG_TRAINING);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trip_delta     <= TRIP_DELTA_RESET;
      cfg.release_margin <= RELEASE_MARGIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRIP_DELTA:     cfg.trip_delta     <= COUNT_BITS'(cfg_data);
        REG_RELEASE_MARGIN: cfg.release_margin <= MARGIN_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  ctt_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .counts      (in_counts),
    .cfg         (cfg),
    .train_load  (train_load),
    .train_value (TRAIN_BITS'(cfg_data)),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign m_tdata = OUT_TDATA_BITS'(out_res);

endmodule
